// ===== rtl/core/gsm_pkg.sv =====
`default_nettype none

package gsm_pkg;

   localparam int VALUE_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_W      = 31;
   localparam int ITER_W     = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int GOLD_W     = 32;

   // (3 - sqrt(5)) / 2 as unsigned q0.32
   localparam logic [GOLD_W-1:0] GOLD_RATIO = 32'h61C88647;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [TOL_W-1:0]          tol_type;
   typedef logic [ITER_W-1:0]         iter_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam value_type FIX_ONE   = value_type'(64'sd1 <<< FRAC_BITS);

   localparam logic OP_START = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BOUND    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BOUND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 2'd3;

   localparam value_type LOWER_RESET    = '0;
   localparam value_type UPPER_RESET    = FIX_ONE;
   localparam tol_type   TOL_RESET      = TOL_W'(66);
   localparam iter_type  MAX_ITER_RESET = ITER_W'(10000);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LIMIT   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PHASE_IDLE  = 4'b0001,
      PHASE_FIRST = 4'b0010,
      PHASE_RIGHT = 4'b0100,
      PHASE_LEFT  = 4'b1000
   } phase_type;

   function automatic value_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_W:0] s;
      s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
      end
      return value_type'(s[VALUE_W-1:0]);
   endfunction

   function automatic value_type sat_sub(input value_type a, input value_type b);
      logic signed [VALUE_W:0] s;
      s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         return s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
      end
      return value_type'(s[VALUE_W-1:0]);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gsm_req_if.sv =====
`default_nettype none

interface gsm_req_if
   import gsm_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      operation;
   value_type function_value;
   logic      value_invalid;

   modport source (output valid, operation, function_value, value_invalid, input ready);
   modport sink   (input valid, operation, function_value, value_invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gsm_rsp_if.sv =====
`default_nettype none

interface gsm_rsp_if
   import gsm_pkg::*;
();
   logic       valid;
   logic       ready;
   value_type  query_point;
   logic       done_res;
   value_type  min_value;
   logic [1:0] status;

   modport source (output valid, query_point, done_res, min_value, status, input ready);
   modport sink   (input valid, query_point, done_res, min_value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gsm_gold_step.sv =====
`default_nettype none

module gsm_gold_step
   import gsm_pkg::*;
(
   input  value_type span,
   output value_type step
);
   localparam int PROD_W = VALUE_W + GOLD_W;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (GOLD_W - 1);

   logic [VALUE_W-1:0] mag;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  rounded;
   logic [VALUE_W-1:0] step_mag;

   // round to nearest on the magnitude, ties away from zero
   assign mag      = span[VALUE_W-1] ? (~span + VALUE_W'(1)) : span;
   assign prod     = mag * GOLD_RATIO;
   assign rounded  = prod + HALF;
   assign step_mag = rounded[PROD_W-1:GOLD_W];
   assign step     = span[VALUE_W-1] ? value_type'(~step_mag + VALUE_W'(1))
                                     : value_type'(step_mag);
endmodule

`default_nettype wire

// ===== rtl/core/gsm_tol_check.sv =====
`default_nettype none

module gsm_tol_check
   import gsm_pkg::*;
(
   input  value_type left_probe,
   input  value_type right_probe,
   input  value_type left_value,
   input  value_type right_value,
   input  tol_type   tolerance,
   output logic      keep_going
);
   localparam int LIMIT_W = VALUE_W + TOL_W;

   logic signed [VALUE_W:0] value_diff;
   logic signed [VALUE_W:0] probe_diff;
   logic [VALUE_W-1:0]      value_gap;
   logic [VALUE_W-1:0]      span_width;
   logic [LIMIT_W-1:0]      limit;
   logic [LIMIT_W-1:0]      scaled_gap;

   assign value_diff = {left_value[VALUE_W-1], left_value}
                     - {right_value[VALUE_W-1], right_value};
   assign value_gap  = value_diff[VALUE_W] ? VALUE_W'(-value_diff) : value_diff[VALUE_W-1:0];

   // interval width, at least one
   assign probe_diff = {right_probe[VALUE_W-1], right_probe}
                     - {left_probe[VALUE_W-1], left_probe};
   assign span_width = (!probe_diff[VALUE_W] && probe_diff[VALUE_W-1:0] >= VALUE_W'(FIX_ONE))
                     ? probe_diff[VALUE_W-1:0] : VALUE_W'(FIX_ONE);

   assign limit      = span_width * tolerance;
   assign scaled_gap = LIMIT_W'({value_gap, {FRAC_BITS{1'b0}}});
   assign keep_going = scaled_gap > limit;
endmodule

`default_nettype wire

// ===== rtl/core/golden_section_minimizer.sv =====
// a request passes the input register, then the result register, before its response
// is valid; one request per cycle while the response channel does not stall.
// the search state closes its loop combinationally through the golden-step
// multipliers and the tolerance multiplier, so a reply may follow the previous.
// reset (synchronous, active high) clears the pipeline valids, puts the search
// idle and loads the configuration defaults.
`default_nettype none

module golden_section_minimizer
   import gsm_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_write_enable,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_write_data,
   gsm_req_if.sink              req_ch,
   gsm_rsp_if.source            rsp_ch
);
   // configuration
   value_type lower_ff;
   value_type upper_ff;
   tol_type   tol_ff;
   iter_type  max_iter_ff;

   // input register
   logic      in_valid_ff;
   logic      in_valid_in;
   logic      in_op_ff;
   value_type in_value_ff;
   logic      in_invalid_ff;

   // search state
   value_type left_end_ff,   left_end_in;
   value_type right_end_ff,  right_end_in;
   value_type left_probe_ff, left_probe_in;
   value_type right_probe_ff, right_probe_in;
   value_type left_val_ff,   left_val_in;
   value_type right_val_ff,  right_val_in;
   iter_type  count_ff,      count_in;
   phase_type phase_ff,      phase_in;
   logic      invalid_ff,    invalid_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_query_ff, rsp_query_in;
   logic       rsp_done_ff,  rsp_done_in;
   value_type  rsp_min_ff,   rsp_min_in;
   status_type rsp_status_ff, rsp_status_in;

   logic      advance;
   logic      take;
   logic      produce;
   value_type span_a, span_b;
   value_type step_a, step_b;
   value_type start_left, start_right;
   value_type eval_left_val, eval_right_val;
   value_type best;
   logic      keep_going;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign take         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (take && produce) || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff    <= LOWER_RESET;
         upper_ff    <= UPPER_RESET;
         tol_ff      <= TOL_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOWER_BOUND:    lower_ff    <= value_type'(csr_write_data[VALUE_W-1:0]);
            CSR_UPPER_BOUND:    upper_ff    <= value_type'(csr_write_data[VALUE_W-1:0]);
            CSR_TOLERANCE:      tol_ff      <= csr_write_data[TOL_W-1:0];
            CSR_MAX_ITERATIONS: max_iter_ff <= csr_write_data[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_op_ff      <= req_ch.operation;
         in_value_ff   <= req_ch.function_value;
         in_invalid_ff <= req_ch.value_invalid;
      end
   end

   // unit a serves the start and the right-probe step, unit b the left-probe step
   assign span_a = (in_op_ff == OP_START) ? sat_sub(upper_ff, lower_ff)
                                          : sat_sub(right_end_ff, left_probe_ff);
   assign span_b = sat_sub(right_probe_ff, left_end_ff);

   gsm_gold_step u_step_a (
      .span (span_a),
      .step (step_a)
   );

   gsm_gold_step u_step_b (
      .span (span_b),
      .step (step_b)
   );

   assign start_left  = sat_add(lower_ff, step_a);
   assign start_right = sat_sub(upper_ff, step_a);

   // probe values with the incoming reply folded in
   assign eval_left_val  = (phase_ff == PHASE_LEFT)  ? in_value_ff : left_val_ff;
   assign eval_right_val = (phase_ff == PHASE_RIGHT) ? in_value_ff : right_val_ff;
   assign best = (count_ff == '0)
               ? ((eval_left_val < eval_right_val) ? eval_left_val : eval_right_val)
               : in_value_ff;

   gsm_tol_check u_tol_check (
      .left_probe  (left_probe_ff),
      .right_probe (right_probe_ff),
      .left_value  (eval_left_val),
      .right_value (eval_right_val),
      .tolerance   (tol_ff),
      .keep_going  (keep_going)
   );

   always_comb begin
      left_end_in    = left_end_ff;
      right_end_in   = right_end_ff;
      left_probe_in  = left_probe_ff;
      right_probe_in = right_probe_ff;
      left_val_in    = left_val_ff;
      right_val_in   = right_val_ff;
      count_in       = count_ff;
      phase_in       = phase_ff;
      invalid_in     = invalid_ff;
      produce        = 1'b0;
      rsp_query_in   = '0;
      rsp_done_in    = 1'b0;
      rsp_min_in     = '0;
      rsp_status_in  = STATUS_OK;

      if (in_op_ff == OP_START) begin
         produce        = 1'b1;
         left_end_in    = lower_ff;
         right_end_in   = upper_ff;
         left_probe_in  = start_left;
         right_probe_in = start_right;
         left_val_in    = '0;
         right_val_in   = '0;
         count_in       = '0;
         invalid_in     = 1'b0;
         phase_in       = PHASE_FIRST;
         rsp_query_in   = start_left;
      end else if (phase_ff != PHASE_IDLE) begin
         produce    = 1'b1;
         invalid_in = invalid_ff || in_invalid_ff;
         case (phase_ff)
            PHASE_FIRST: begin
               left_val_in  = in_value_ff;
               phase_in     = PHASE_RIGHT;
               rsp_query_in = right_probe_ff;
            end
            PHASE_RIGHT, PHASE_LEFT: begin
               left_val_in  = eval_left_val;
               right_val_in = eval_right_val;
               if (invalid_in) begin
                  rsp_done_in   = 1'b1;
                  rsp_status_in = STATUS_INVALID;
                  phase_in      = PHASE_IDLE;
               end else if (count_ff >= max_iter_ff) begin
                  rsp_done_in   = 1'b1;
                  rsp_min_in    = best;
                  rsp_status_in = STATUS_LIMIT;
                  phase_in      = PHASE_IDLE;
               end else if (!keep_going) begin
                  rsp_done_in   = 1'b1;
                  rsp_min_in    = best;
                  phase_in      = PHASE_IDLE;
               end else begin
                  count_in = count_ff + ITER_W'(1);
                  if (eval_left_val > eval_right_val) begin
                     // minimum lies right of the left probe
                     left_end_in    = left_probe_ff;
                     left_probe_in  = right_probe_ff;
                     left_val_in    = eval_right_val;
                     right_probe_in = sat_sub(right_end_ff, step_a);
                     rsp_query_in   = right_probe_in;
                     phase_in       = PHASE_RIGHT;
                  end else begin
                     right_end_in   = right_probe_ff;
                     right_probe_in = left_probe_ff;
                     right_val_in   = eval_left_val;
                     left_probe_in  = sat_add(left_end_ff, step_b);
                     rsp_query_in   = left_probe_in;
                     phase_in       = PHASE_LEFT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
         end
      end
      if (take) begin
         left_end_ff    <= left_end_in;
         right_end_ff   <= right_end_in;
         left_probe_ff  <= left_probe_in;
         right_probe_ff <= right_probe_in;
         left_val_ff    <= left_val_in;
         right_val_ff   <= right_val_in;
         count_ff       <= count_in;
         invalid_ff     <= invalid_in;
      end
      if (take && produce) begin
         rsp_query_ff  <= rsp_query_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_min_ff    <= rsp_min_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.query_point = rsp_query_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.min_value   = rsp_min_ff;
   assign rsp_ch.status      = rsp_status_ff;

   a_start_opens_search: assert property (@(posedge clock) disable iff (reset)
      (take && in_op_ff == OP_START) |=> (phase_ff == PHASE_FIRST))
      else $error("start request did not open a search");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (take && produce && rsp_done_in) |=> (phase_ff == PHASE_IDLE && rsp_valid_ff))
      else $error("finished search not idle or response lost");

   a_idle_reply_dropped: assert property (@(posedge clock) disable iff (reset)
      (take && in_op_ff == OP_REPLY && phase_ff == PHASE_IDLE && rsp_ch.ready)
      |=> !rsp_valid_ff)
      else $error("reply while idle produced a response");

   a_running_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> (rsp_status_ff == STATUS_OK && rsp_min_ff == '0))
      else $error("running response carries status or minimum");
endmodule

`default_nettype wire
